FILE: rtl/core/bmsa_pkg.sv
// Package for the per-bin mean and standard error accumulator.
// Holds field widths, default parameters and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package bmsa_pkg;

    localparam int DEF_BINS       = 1024;
    localparam int DEF_VALUE_BITS = 24;
    localparam int DEF_COUNT_BITS = 16;

    localparam int IDX_W = 10;
    localparam int VAL_W = 24;
    localparam int OUT_W = 24;
    localparam int EVT_W = 16;
    localparam int SUM_W = 40;
    localparam int SQ_W  = 64;
    localparam int DIV_W = 64;
    localparam int ROOT_W = 32;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;
    localparam logic [EVT_W-1:0] EVT_MAX = '1;

    typedef enum logic [1:0] {
        DS_SUM = 2'd0,
        DS_SQ  = 2'd1,
        DS_VAR = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     accept;
        logic     clear_step;
        logic     acc_write;
        logic     div_start;
        div_sel_t div_sel;
        logic     latch_m;
        logic     latch_e2;
        logic     mul_m2;
        logic     sqrt_start;
        logic     load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic n_zero;
        logic div_busy;
        logic div_done;
        logic sqrt_done;
    } dp_stat_t;

endpackage

FILE: rtl/core/binwise_mean_stderr_accumulator.sv
// Top level of the per-bin mean and standard error accumulator.
// Depends on bmsa_pkg, bmsa_ctrl and bmsa_datapath.
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | operation, bin_index, bin_value, last_of_event
//  m_      | out       | m_valid / m_ready  | bin_mean, bin_std_error, events_seen, no_events
//
// An accumulate beat reads memory on accept and does the saturating write-back next.
// A read beat runs three passes of the shared bit-serial divider and then the square
// root; a zero count skips straight to the final state.
// After reset a clearing pass writes one bin a cycle through all BINS bins; s_ready stays low.
// A result waits in the output register; accumulate beats are taken meanwhile, and a
// following read holds in its final state until that register is free.

module binwise_mean_stderr_accumulator #(
    parameter int BINS       = bmsa_pkg::DEF_BINS,
    parameter int VALUE_BITS = bmsa_pkg::DEF_VALUE_BITS,
    parameter int COUNT_BITS = bmsa_pkg::DEF_COUNT_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [bmsa_pkg::IDX_W-1:0]  s_bin_index,
    input  logic [bmsa_pkg::VAL_W-1:0]  s_bin_value,
    input  logic                        s_last_of_event,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bmsa_pkg::OUT_W-1:0]  m_bin_mean,
    output logic [bmsa_pkg::OUT_W-1:0]  m_bin_std_error,
    output logic [bmsa_pkg::EVT_W-1:0]  m_events_seen,
    output logic                        m_no_events
);

    bmsa_pkg::ctrl_cmd_t cmd;
    bmsa_pkg::dp_stat_t  stat;

    // Sequence clear, accumulate and read steps.
    bmsa_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .stat        (stat)
    );

    // Hold the bin store, count and read arithmetic.
    bmsa_datapath #(
        .BINS       (BINS),
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_bin_index     (s_bin_index),
        .s_bin_value     (s_bin_value),
        .s_last_of_event (s_last_of_event),
        .m_bin_mean      (m_bin_mean),
        .m_bin_std_error (m_bin_std_error),
        .m_events_seen   (m_events_seen),
        .m_no_events     (m_no_events)
    );

endmodule

FILE: rtl/core/bmsa_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on bmsa_pkg.
`timescale 1ns / 1ps

module bmsa_div #(
    parameter int COUNT_BITS = bmsa_pkg::DEF_COUNT_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [bmsa_pkg::DIV_W-1:0]   dividend,
    input  logic [COUNT_BITS-1:0]        divisor,
    output logic [bmsa_pkg::DIV_W-1:0]   quotient,
    output logic                         busy,
    output logic                         done
);

    localparam int CW = $clog2(bmsa_pkg::DIV_W);

    logic [bmsa_pkg::DIV_W-1:0] q_reg;
    logic [COUNT_BITS-1:0]      rem_reg;
    logic [COUNT_BITS-1:0]      d_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [COUNT_BITS:0] trial;
    logic [COUNT_BITS:0] diff;
    logic                ge;
    logic                last_step;

    assign trial     = {rem_reg, q_reg[bmsa_pkg::DIV_W-1]};
    assign ge        = trial >= {1'b0, d_reg};
    assign diff      = trial - {1'b0, d_reg};
    assign last_step = busy_reg && (cnt_reg == CW'(bmsa_pkg::DIV_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && last_step;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[bmsa_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        end
    end

    assign quotient = q_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

FILE: rtl/core/bmsa_sqrt.sv
// Bit-pair integer square root of a 64-bit radicand, one pair per cycle.
// Depends on bmsa_pkg.
`timescale 1ns / 1ps

module bmsa_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [bmsa_pkg::DIV_W-1:0]  radicand,
    output logic [bmsa_pkg::ROOT_W-1:0] root,
    output logic                        done
);

    localparam int W = bmsa_pkg::DIV_W;

    logic [W-1:0] x_reg;
    logic [W-1:0] r_reg;
    logic [W-1:0] bit_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [W-1:0] t;

    assign t = r_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && busy_reg && bit_reg[0];
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= W'(1) << (W - 2);
        end else if (busy_reg) begin
            if (x_reg >= t) begin
                x_reg <= x_reg - t;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = r_reg[bmsa_pkg::ROOT_W-1:0];
    assign done = done_reg;

endmodule

FILE: rtl/core/bmsa_datapath.sv
// Datapath: bin store, saturating accumulate, event count, read arithmetic.
// Depends on bmsa_pkg, bmsa_div and bmsa_sqrt.
`timescale 1ns / 1ps

module bmsa_datapath #(
    parameter int BINS       = bmsa_pkg::DEF_BINS,
    parameter int VALUE_BITS = bmsa_pkg::DEF_VALUE_BITS,
    parameter int COUNT_BITS = bmsa_pkg::DEF_COUNT_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bmsa_pkg::ctrl_cmd_t         cmd,
    output bmsa_pkg::dp_stat_t          stat,
    input  logic [bmsa_pkg::IDX_W-1:0]  s_bin_index,
    input  logic [bmsa_pkg::VAL_W-1:0]  s_bin_value,
    input  logic                        s_last_of_event,
    output logic [bmsa_pkg::OUT_W-1:0]  m_bin_mean,
    output logic [bmsa_pkg::OUT_W-1:0]  m_bin_std_error,
    output logic [bmsa_pkg::EVT_W-1:0]  m_events_seen,
    output logic                        m_no_events
);

    localparam int AW = $clog2(BINS);
    localparam int PW = 2 * VALUE_BITS;
    localparam int SW = bmsa_pkg::SUM_W;
    localparam int QW = bmsa_pkg::SQ_W;
    localparam int MW = SW + QW;

    logic [MW-1:0] mem [0:BINS-1];

    logic [31:0]           idx_ext;
    logic                  in_range_in;
    logic [AW-1:0]         addr_in;
    logic [VALUE_BITS-1:0] val_in;
    logic [PW-1:0]         val_wide;

    logic [MW-1:0]         rd_reg;
    logic [AW-1:0]         addr_reg;
    logic                  in_range_reg;
    logic                  last_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [PW-1:0]         sq_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [AW-1:0]         clr_addr_reg;

    logic [SW-1:0]  rd_sum;
    logic [QW-1:0]  rd_sq;
    logic [SW:0]    sum_add;
    logic [QW:0]    sq_add;
    logic [SW-1:0]  sum_new;
    logic [QW-1:0]  sq_new;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [MW-1:0]  wr_data;

    logic [SW-1:0]  m_reg;
    logic [QW-1:0]  e2_reg;
    logic [QW-1:0]  m2_reg;
    logic           m_big_reg;
    logic [QW-1:0]  var_val;
    logic [QW-1:0]  div_in;
    logic [QW-1:0]  div_q;
    logic           div_busy;
    logic           div_done;
    logic [bmsa_pkg::ROOT_W-1:0] root;
    logic           sqrt_done;
    logic [31:0]    cnt_ext;

    logic [bmsa_pkg::OUT_W-1:0] mean_reg;
    logic [bmsa_pkg::OUT_W-1:0] err_reg;
    logic [bmsa_pkg::EVT_W-1:0] evt_reg;
    logic                       nz_reg;

    assign idx_ext     = 32'(s_bin_index);
    assign in_range_in = idx_ext < 32'(BINS);
    assign addr_in     = idx_ext[AW-1:0];
    assign val_in      = VALUE_BITS'(s_bin_value);
    assign val_wide    = PW'(val_in);

    assign rd_sum  = rd_reg[MW-1:QW];
    assign rd_sq   = rd_reg[QW-1:0];
    assign sum_add = {1'b0, rd_sum} + (SW + 1)'(val_reg);
    assign sq_add  = {1'b0, rd_sq} + (QW + 1)'(sq_reg);
    assign sum_new = sum_add[SW] ? '1 : sum_add[SW-1:0];
    assign sq_new  = sq_add[QW] ? '1 : sq_add[QW-1:0];

    assign wr_en   = cmd.clear_step | (cmd.acc_write & in_range_reg);
    assign wr_addr = cmd.clear_step ? clr_addr_reg : addr_reg;
    assign wr_data = cmd.clear_step ? '0 : {sum_new, sq_new};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.accept) begin
            rd_reg <= mem[addr_in];
        end
    end

    // Latch the beat; square the value on the way in.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            addr_reg     <= addr_in;
            in_range_reg <= in_range_in;
            last_reg     <= s_last_of_event;
            val_reg      <= val_in;
            sq_reg       <= val_wide * val_wide;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            clr_addr_reg <= '0;
        end else begin
            if (cmd.clear_step) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.acc_write && last_reg && (count_reg != '1)) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    assign var_val = (!m_big_reg && (e2_reg > m2_reg)) ? (e2_reg - m2_reg) : '0;

    always_comb begin
        case (cmd.div_sel)
            bmsa_pkg::DS_SUM: div_in = in_range_reg ? QW'(rd_sum) : '0;
            bmsa_pkg::DS_SQ:  div_in = in_range_reg ? rd_sq : '0;
            default:          div_in = var_val;
        endcase
    end

    bmsa_div #(
        .COUNT_BITS(COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_in),
        .divisor  (count_reg),
        .quotient (div_q),
        .busy     (div_busy),
        .done     (div_done)
    );

    bmsa_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (div_q),
        .root     (root),
        .done     (sqrt_done)
    );

    always_ff @(posedge aclk) begin
        if (cmd.latch_m) begin
            m_reg <= div_q[SW-1:0];
        end
        if (cmd.latch_e2) begin
            e2_reg <= div_q;
        end
        if (cmd.mul_m2) begin
            m2_reg    <= QW'(m_reg[31:0]) * QW'(m_reg[31:0]);
            m_big_reg <= |m_reg[SW-1:32];
        end
    end

    assign cnt_ext = 32'(count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            nz_reg  <= (count_reg == '0);
            evt_reg <= (cnt_ext > 32'(bmsa_pkg::EVT_MAX)) ? bmsa_pkg::EVT_MAX
                                                          : cnt_ext[bmsa_pkg::EVT_W-1:0];
            if (count_reg == '0) begin
                mean_reg <= '0;
                err_reg  <= '0;
            end else begin
                mean_reg <= (m_reg > SW'(bmsa_pkg::OUT_MAX)) ? bmsa_pkg::OUT_MAX
                                                             : m_reg[bmsa_pkg::OUT_W-1:0];
                err_reg  <= (root > bmsa_pkg::ROOT_W'(bmsa_pkg::OUT_MAX)) ? bmsa_pkg::OUT_MAX
                                                          : root[bmsa_pkg::OUT_W-1:0];
            end
        end
    end

    assign stat.clear_last = (clr_addr_reg == AW'(BINS - 1));
    assign stat.n_zero     = (count_reg == '0);
    assign stat.div_busy   = div_busy;
    assign stat.div_done   = div_done;
    assign stat.sqrt_done  = sqrt_done;

    assign m_bin_mean      = mean_reg;
    assign m_bin_std_error = err_reg;
    assign m_events_seen   = evt_reg;
    assign m_no_events     = nz_reg;

endmodule

FILE: rtl/core/bmsa_ctrl.sv
// Controller: clear pass, accumulate write-back and read sequencing.
// Depends on bmsa_pkg.
`timescale 1ns / 1ps

module bmsa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_operation,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bmsa_pkg::ctrl_cmd_t  cmd,
    input  bmsa_pkg::dp_stat_t   stat
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC_WR,
        ST_RD_LOAD,
        ST_DIV_M,
        ST_DIV_E,
        ST_MUL,
        ST_VAR,
        ST_DIV_V,
        ST_SQRT,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = accept;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = s_operation ? ST_RD_LOAD : ST_ACC_WR;
                end
            end
            ST_ACC_WR: begin
                cmd.acc_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_RD_LOAD: begin
                if (stat.n_zero) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = bmsa_pkg::DS_SUM;
                    state_next    = ST_DIV_M;
                end
            end
            ST_DIV_M: begin
                if (stat.div_done) begin
                    cmd.latch_m   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = bmsa_pkg::DS_SQ;
                    state_next    = ST_DIV_E;
                end
            end
            ST_DIV_E: begin
                if (stat.div_done) begin
                    cmd.latch_e2 = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_m2 = 1'b1;
                state_next = ST_VAR;
            end
            ST_VAR: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = bmsa_pkg::DS_VAR;
                state_next    = ST_DIV_V;
            end
            ST_DIV_V: begin
                if (stat.div_done) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (stat.sqrt_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef NO_ASSERTIONS
    a_div_idle_on_start : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");

    a_acc_writes_back : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_operation) |=> cmd.acc_write)
        else $error("accumulate beat not written back");

    a_out_not_overrun : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before taken");

    a_read_gives_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_operation) |=> !cmd.acc_write)
        else $error("read beat treated as accumulate");
`endif

endmodule

FILE: sim/bmsa_tb_pkg.sv
// Shared codes for the accumulator testbench: the item operation encoding.
// Used by bmsa_checker and tb. No dependencies.
`timescale 1ns / 1ps

package bmsa_tb_pkg;

    typedef enum logic {
        OP_ACCUMULATE = 1'b0,
        OP_READ       = 1'b1
    } bin_op_t;

endpackage

FILE: sim/bmsa_checker.sv
// Watches both channels of the accumulator, keeps its own bin sums and event count,
// predicts every read result and compares it. Depends on bmsa_pkg and bmsa_tb_pkg.
`timescale 1ns / 1ps

module bmsa_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_operation,
    input  logic [bmsa_pkg::IDX_W-1:0]  s_bin_index,
    input  logic [bmsa_pkg::VAL_W-1:0]  s_bin_value,
    input  logic                        s_last_of_event,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [bmsa_pkg::OUT_W-1:0]  m_bin_mean,
    input  logic [bmsa_pkg::OUT_W-1:0]  m_bin_std_error,
    input  logic [bmsa_pkg::EVT_W-1:0]  m_events_seen,
    input  logic                        m_no_events,
    output int                          mismatches,
    output int                          awaited
);

    typedef struct packed {
        logic [bmsa_pkg::OUT_W-1:0] mean;
        logic [bmsa_pkg::OUT_W-1:0] std_error;
        logic [bmsa_pkg::EVT_W-1:0] events;
        logic                       empty;
    } bin_stats_t;

    logic [bmsa_pkg::SUM_W-1:0] sum_store [1024];
    logic [bmsa_pkg::SQ_W-1:0]  sq_store  [1024];
    logic [15:0]                events_merged;
    bin_stats_t                 stats_due [$];

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [bmsa_pkg::OUT_W-1:0] clip24(input logic [63:0] v);
        return (v > 64'hFFFFFF) ? bmsa_pkg::OUT_MAX : v[bmsa_pkg::OUT_W-1:0];
    endfunction

    function automatic bin_stats_t bin_stats(input logic [9:0] idx);
        logic [63:0] n, m, e2, var_q, m2;
        bin_stats_t  r;
        n = {48'd0, events_merged};
        r = '0;
        r.events = events_merged;
        r.empty  = (events_merged == 0);
        if (!r.empty) begin
            m     = {24'd0, sum_store[idx]} / n;
            e2    = sq_store[idx] / n;
            var_q = 0;
            if (m <= 64'hFFFF_FFFF) begin
                m2 = m * m;
                if (e2 > m2) var_q = e2 - m2;
            end
            r.mean      = clip24(m);
            r.std_error = clip24(isqrt(var_q / n));
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s at %0t: got %0h, expected %0h", what, $time, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        bin_stats_t  want;
        logic [64:0] sq_next;
        logic [40:0] sum_next;
        logic [47:0] sq_val;
        if (!aresetn) begin
            for (int i = 0; i < 1024; i++) begin
                sum_store[i] = '0;
                sq_store[i]  = '0;
            end
            events_merged = 0;
            stats_due.delete();
            mismatches = 0;
        end else begin
            // compare a delivered result against the oldest prediction
            if (m_valid && m_ready) begin
                if (stats_due.size() == 0) begin
                    report("unexpected result beat", 0, 0);
                end else begin
                    want = stats_due.pop_front();
                    if (m_bin_mean !== want.mean)
                        report("bin_mean", m_bin_mean, want.mean);
                    if (m_bin_std_error !== want.std_error)
                        report("bin_std_error", m_bin_std_error, want.std_error);
                    if (m_events_seen !== want.events)
                        report("events_seen", m_events_seen, want.events);
                    if (m_no_events !== want.empty)
                        report("no_events", m_no_events, want.empty);
                end
            end
            if (s_valid && s_ready) begin
                if (s_operation == bmsa_tb_pkg::OP_READ) begin
                    stats_due = {stats_due, bin_stats(s_bin_index)};
                end else begin
                    sq_val   = s_bin_value * s_bin_value;
                    sum_next = sum_store[s_bin_index] + s_bin_value;
                    sq_next  = sq_store[s_bin_index] + sq_val;
                    sum_store[s_bin_index] = sum_next[40] ? '1 : sum_next[39:0];
                    sq_store[s_bin_index]  = sq_next[64] ? '1 : sq_next[63:0];
                    if (s_last_of_event && events_merged != 16'hFFFF)
                        events_merged++;
                end
            end
        end
        awaited = stats_due.size();
    end

endmodule

FILE: sim/tb.sv
// Top of the accumulator testbench: clock, reset, stimulus, back-pressure and verdict.
// Depends on bmsa_pkg, bmsa_tb_pkg, bmsa_checker and binwise_mean_stderr_accumulator.
`timescale 1ns / 1ps

module tb;

    localparam int ITEM_TARGET = 1800;
    // clearing pass plus a full read plus stalls, with ample margin
    localparam int STALL_LIMIT = 6000;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_operation = bmsa_tb_pkg::OP_ACCUMULATE;
    logic [bmsa_pkg::IDX_W-1:0] s_bin_index = '0;
    logic [bmsa_pkg::VAL_W-1:0] s_bin_value = '0;
    logic                       s_last_of_event = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [bmsa_pkg::OUT_W-1:0] m_bin_mean;
    logic [bmsa_pkg::OUT_W-1:0] m_bin_std_error;
    logic [bmsa_pkg::EVT_W-1:0] m_events_seen;
    logic                       m_no_events;

    int   mismatches;
    int   awaited;
    int   items_sent = 0;
    int   idle_count = 0;
    bit   no_gaps = 1'b0;     // phase flag: drop all idling on both sides
    logic s_beat = 1'b0;      // beat taken at the last rising edge
    logic m_beat = 1'b0;

    always #6 aclk = ~aclk;

    binwise_mean_stderr_accumulator dut (.*);

    bmsa_checker u_checker (.*);

    // Record beats at the edge where they happen; drivers read them at the falling edge.
    always @(posedge aclk) begin
        s_beat <= s_valid && s_ready;
        m_beat <= m_valid && m_ready;
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // Result side: hold ready low for a random stall, then wait for the beat.
    initial begin
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(negedge aclk); while (!m_beat);
        end
    end

    // Present one beat after a random gap and hold it until accepted.
    // Enter and leave at a falling edge.
    task automatic send(input bmsa_tb_pkg::bin_op_t op, input logic [bmsa_pkg::IDX_W-1:0] idx,
                        input logic [bmsa_pkg::VAL_W-1:0] val, input logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_operation     = op;
        s_bin_index     = idx;
        s_bin_value     = val;
        s_last_of_event = last;
        s_valid         = 1'b1;
        do @(negedge aclk); while (!s_beat);
        items_sent++;
    endtask

    // Pick a bin: mostly a small hot set so reads see real history.
    function automatic logic [bmsa_pkg::IDX_W-1:0] pick_bin();
        return ($urandom_range(0, 9) < 7) ? bmsa_pkg::IDX_W'($urandom_range(0, 15))
                                         : bmsa_pkg::IDX_W'($urandom);
    endfunction

    // Value mix: full range, small, and the extremes.
    function automatic logic [bmsa_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return '1;
            1:       return '0;
            2, 3:    return bmsa_pkg::VAL_W'($urandom_range(0, 4095));
            default: return bmsa_pkg::VAL_W'($urandom);
        endcase
    endfunction

    initial begin
        int  burst;
        bit  paused = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: empty count, saturated mean with clamped variance, top bin,
        // ignored last flag on a read, a bin with a nonzero error.
        send(bmsa_tb_pkg::OP_READ, 10'd0, '0, 1'b0);
        send(bmsa_tb_pkg::OP_ACCUMULATE, 10'd5, '1, 1'b0);
        send(bmsa_tb_pkg::OP_READ, 10'd5, '0, 1'b0);
        send(bmsa_tb_pkg::OP_ACCUMULATE, 10'd5, '1, 1'b0);
        send(bmsa_tb_pkg::OP_ACCUMULATE, 10'd1023, '0, 1'b1);
        send(bmsa_tb_pkg::OP_READ, 10'd5, '0, 1'b0);
        send(bmsa_tb_pkg::OP_READ, 10'd1023, '1, 1'b1);
        send(bmsa_tb_pkg::OP_ACCUMULATE, 10'd1023, '1, 1'b0);
        send(bmsa_tb_pkg::OP_READ, 10'd1023, '0, 1'b0);
        send(bmsa_tb_pkg::OP_ACCUMULATE, 10'd7, 24'h000100, 1'b1);
        send(bmsa_tb_pkg::OP_ACCUMULATE, 10'd7, 24'h000300, 1'b1);
        send(bmsa_tb_pkg::OP_ACCUMULATE, 10'd0, 24'h000001, 1'b1);
        send(bmsa_tb_pkg::OP_READ, 10'd7, '0, 1'b0);
        send(bmsa_tb_pkg::OP_READ, 10'd0, '0, 1'b0);
        send(bmsa_tb_pkg::OP_READ, 10'd700, '0, 1'b0);

        // Random: whole events of a few accumulates closed by the last flag,
        // reads after many events, and some stray accumulates as noise.
        while (items_sent < ITEM_TARGET) begin
            no_gaps = ((items_sent / 300) % 3) == 1;
            if (!paused && items_sent > ITEM_TARGET / 2) begin
                // hold the sender until every read result has drained
                s_valid = 1'b0;
                while (awaited != 0) @(negedge aclk);
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                send(bmsa_tb_pkg::OP_ACCUMULATE, pick_bin(), pick_value(), 1'($urandom));
            end else begin
                burst = $urandom_range(1, 6);
                for (int k = 0; k < burst; k++)
                    send(bmsa_tb_pkg::OP_ACCUMULATE, pick_bin(), pick_value(),
                         k == burst - 1);
            end
            if ($urandom_range(0, 9) < 4)
                send(bmsa_tb_pkg::OP_READ, pick_bin(), bmsa_pkg::VAL_W'($urandom),
                     1'($urandom));
        end
        s_valid = 1'b0;

        while (awaited != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/bmsa_pkg.sv
rtl/core/bmsa_div.sv
rtl/core/bmsa_sqrt.sv
rtl/core/bmsa_datapath.sv
rtl/core/bmsa_ctrl.sv
rtl/core/binwise_mean_stderr_accumulator.sv
sim/bmsa_tb_pkg.sv
sim/bmsa_checker.sv
sim/tb.sv
